FILE: design/xy_lattice_spin_engine_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the XY lattice spin engine
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef XY_LATTICE_SPIN_ENGINE_DEFINES_SVH
`define XY_LATTICE_SPIN_ENGINE_DEFINES_SVH

// same-cycle implication
`define XYL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XYL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/xyl_pkg.sv
// ---------------------------------------------------------------------------
// xyl_pkg
// Types, constants and helper functions shared by the XY lattice spin engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xyl_pkg;

  // lattice geometry; SIDE is a power of two so a site address is {row, col}
  localparam int SIDE       = 64;
  localparam int RC_W       = $clog2(SIDE);
  localparam int ADDR_W     = 2 * RC_W;
  localparam int NSITES     = SIDE * SIDE;
  localparam int PHASE_BITS = 16;
  localparam int WIDE_W     = 32;
  localparam int UPSHIFT    = WIDE_W - PHASE_BITS;

  // arithmetic widths
  localparam int ACC_W      = 32;
  localparam int SIN_W      = 18;
  localparam int VAL_W      = 31;
  localparam int VAL_LIMIT  = 536870912;
  localparam int LIM_BIT    = 29;
  localparam int CRD_W      = 56;
  localparam int CRD_PRE    = 20;
  localparam int CORDIC_STEPS = 21;
  localparam int SQ_W       = 64;
  localparam int SQ_STEPS   = 32;
  localparam int STEP_W     = 5;

  localparam logic [WIDE_W-1:0] QUARTER = 32'h4000_0000;
  localparam logic [WIDE_W-1:0] HALF    = 32'h8000_0000;
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  // operation kinds
  localparam logic [2:0] K_SET   = 3'd0;
  localparam logic [2:0] K_ROT   = 3'd1;
  localparam logic [2:0] K_DELTA = 3'd2;
  localparam logic [2:0] K_SITE  = 3'd3;
  localparam logic [2:0] K_ORX   = 3'd4;
  localparam logic [2:0] K_TOTAL = 3'd5;
  localparam logic [2:0] K_MAG   = 3'd6;

  // store address select
  localparam logic [2:0] AD_CTR      = 3'd0;
  localparam logic [2:0] AD_LEFT     = 3'd1;
  localparam logic [2:0] AD_RIGHT    = 3'd2;
  localparam logic [2:0] AD_DOWN     = 3'd3;
  localparam logic [2:0] AD_UP       = 3'd4;
  localparam logic [2:0] AD_SCAN     = 3'd5;
  localparam logic [2:0] AD_SC_DOWN  = 3'd6;
  localparam logic [2:0] AD_SC_RIGHT = 3'd7;

  // store write data select
  localparam logic [1:0] WR_ZERO = 2'd0;
  localparam logic [1:0] WR_ARG  = 2'd1;
  localparam logic [1:0] WR_ROT  = 2'd2;
  localparam logic [1:0] WR_OR   = 2'd3;

  // read data capture target
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_CTR  = 2'd1;
  localparam logic [1:0] CAP_TH   = 2'd2;
  localparam logic [1:0] CAP_NB   = 2'd3;

  // trig phase select
  localparam logic [2:0] PH_DIFF   = 3'd0;
  localparam logic [2:0] PH_DIFFD  = 3'd1;
  localparam logic [2:0] PH_NB_COS = 3'd2;
  localparam logic [2:0] PH_NB_SIN = 3'd3;
  localparam logic [2:0] PH_TH_COS = 3'd4;
  localparam logic [2:0] PH_TH_SIN = 3'd5;

  // accumulator operations
  localparam logic [1:0] ACC_ADD_V = 2'd0;
  localparam logic [1:0] ACC_SUB_V = 2'd1;
  localparam logic [1:0] ACC_ADD_X = 2'd2;
  localparam logic [1:0] ACC_ADD_Y = 2'd3;

  typedef struct packed {
    logic              in_rdy;
    logic              mem_rd;
    logic              mem_wr;
    logic [2:0]        addr_sel;
    logic [1:0]        wr_sel;
    logic [1:0]        cap_sel;
    logic [1:0]        idx;
    logic              trig_go;
    logic [2:0]        ph_sel;
    logic [1:0]        acc_op;
    logic              scan_clr;
    logic              scan_inc;
    logic              set_degen;
    logic              cord_init;
    logic              cord_step;
    logic              sq_abs;
    logic              sq_x;
    logic              sq_y;
    logic              sq_step;
    logic [STEP_W-1:0] step;
    logic              res_load;
  } xyl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] kind;
    logic       trig_done;
    logic       scan_last;
    logic       h_zero;
    logic       out_free;
  } xyl_sts_t;

  // periodic neighbour index
  function automatic logic [RC_W-1:0] rc_inc(input logic [RC_W-1:0] v);
    return (v == RC_W'(SIDE - 1)) ? '0 : v + RC_W'(1);
  endfunction

  function automatic logic [RC_W-1:0] rc_dec(input logic [RC_W-1:0] v);
    return (v == '0) ? RC_W'(SIDE - 1) : v - RC_W'(1);
  endfunction

  // stored phase to full 32-bit circle
  function automatic logic [WIDE_W-1:0] to_wide(input logic [PHASE_BITS-1:0] a);
    return {a, {UPSHIFT{1'b0}}};
  endfunction

  // CORDIC arctangent table, 2^32 to the circle
  function automatic logic [WIDE_W-1:0] arc_at(input logic [STEP_W-1:0] i);
    logic [WIDE_W-1:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/xyl_if.sv
// ---------------------------------------------------------------------------
// xyl_if
// Valid/ready channel interfaces for operation requests and results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface xyl_in_if import xyl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [5:0]            row;
  logic [5:0]            col;
  logic [PHASE_BITS-1:0] angle;

  modport source (output valid, kind, row, col, angle, input ready);
  modport sink   (input valid, kind, row, col, angle, output ready);
endinterface

interface xyl_out_if import xyl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [PHASE_BITS-1:0]   new_angle;
  logic                    degenerate;

  modport source (output valid, value, new_angle, degenerate, input ready);
  modport sink   (input valid, value, new_angle, degenerate, output ready);
endinterface

`default_nettype wire

FILE: design/xyl_sin.sv
// ---------------------------------------------------------------------------
// xyl_sin
// Five-stage polynomial sine, 32-bit phase in, Q16 result out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xyl_sin
  import xyl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [WIDE_W-1:0]       phase,
  output logic                         done,
  output logic signed [SIN_W-1:0]      result
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [30:0] x1_r, x2_r, x3_r, x4_r;
  logic [30:0] xx2_r, xx3_r;
  logic [29:0] u3_r;
  logic [30:0] w4_r;
  logic signed [SIN_W-1:0] res_r;

  logic [61:0] sq1;
  logic [57:0] pc2;
  logic [60:0] pw3;
  logic [61:0] ps4;
  logic [31:0] rnd4;
  logic [SIN_W-1:0] mag4;

  assign sq1  = x1_r * x1_r;
  assign pc2  = SIN_C * xx2_r;
  assign pw3  = xx3_r * u3_r;
  assign ps4  = x4_r * w4_r;
  assign rnd4 = ps4[61:30] + 32'd8192;
  assign mag4 = rnd4[31:14];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // datapath stages: fold to first quadrant, x^2, inner, outer, final product
  always_ff @(posedge clk) begin
    q1_r  <= phase[31:30];
    x1_r  <= phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    q2_r  <= q1_r;
    x2_r  <= x1_r;
    xx2_r <= sq1[60:30];
    q3_r  <= q2_r;
    x3_r  <= x2_r;
    xx3_r <= xx2_r;
    u3_r  <= SIN_B - {2'b0, pc2[57:30]};
    q4_r  <= q3_r;
    x4_r  <= x3_r;
    w4_r  <= SIN_A - pw3[60:30];
    res_r <= q4_r[1] ? -$signed(mag4) : $signed(mag4);
  end

  assign done   = v5_r;
  assign result = res_r;

endmodule

`default_nettype wire

FILE: design/xyl_datapath.sv
// ---------------------------------------------------------------------------
// xyl_datapath
// Angle store, site registers, accumulators, CORDIC, square root and the
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xyl_datapath
  import xyl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  xyl_in_if.sink        in_ch,
  xyl_out_if.source     out_ch,
  input  wire xyl_cmd_t cmd,
  output xyl_sts_t      sts
);

  localparam logic signed [ACC_W-1:0] VAL_LIM = ACC_W'(VAL_LIMIT);
  localparam logic [SQ_W-1:0]         SQ_LIM  = SQ_W'(VAL_LIMIT);

  function automatic logic signed [CRD_W-1:0] shr_s(input logic signed [CRD_W-1:0] v,
                                                  input logic [STEP_W-1:0] n);
    logic signed [CRD_W-1:0] m;
    m = -v;
    return v[CRD_W-1] ? -(m >>> n) : (v >>> n);
  endfunction

  logic                  acc_in;
  logic [2:0]            kind_r;
  logic [RC_W-1:0]       row_r, col_r;
  logic [PHASE_BITS-1:0] arg_r;
  logic [PHASE_BITS-1:0] th_r, na_r;
  logic [PHASE_BITS-1:0] nb_r [4];
  logic [RC_W-1:0]       scan_i_r, scan_j_r;

  logic [PHASE_BITS-1:0] mem [NSITES];
  logic [PHASE_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]     addr;
  logic [PHASE_BITS-1:0] wdata;
  logic [1:0]            cap_sel_d_r;
  logic [1:0]            cap_idx_d_r;

  logic signed [ACC_W-1:0] acc_v_r, acc_x_r, acc_y_r;
  logic [1:0]              pend_op_r;
  logic [WIDE_W-1:0]       phase;
  logic                    trig_done;
  logic signed [SIN_W-1:0] sin_res;
  logic signed [ACC_W-1:0] sin_ext;

  logic signed [CRD_W-1:0] cx_r, cy_r;
  logic [WIDE_W-1:0]       cz_r;
  logic signed [ACC_W-1:0] xs, ys;
  logic signed [CRD_W-1:0] dx, dy;
  logic [WIDE_W-1:0]       or_wide;

  logic [SQ_W-1:0] sq_v_r, sq_res_r, sq_bit_r, sq_trial;
  logic            sq_big_r;
  logic [59:0]     sq_px, sq_py;

  logic                    degen_r;
  logic                    out_v_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [PHASE_BITS-1:0]   out_na_r;
  logic                    out_dg_r;
  logic signed [VAL_W-1:0] val_sat, val_res;

  assign acc_in      = in_ch.valid && cmd.in_rdy;
  assign in_ch.ready = cmd.in_rdy;

  // request latch
  always_ff @(posedge clk) begin
    if (acc_in) begin
      kind_r <= in_ch.kind;
      row_r  <= in_ch.row;
      col_r  <= in_ch.col;
      arg_r  <= in_ch.angle;
    end
  end

  // lattice scan counter, also drives the clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_clr) begin
      scan_i_r <= '0;
      scan_j_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_j_r <= rc_inc(scan_j_r);
      if (scan_j_r == RC_W'(SIDE - 1)) scan_i_r <= rc_inc(scan_i_r);
    end
  end

  // store address
  always_comb begin
    unique case (cmd.addr_sel)
      AD_CTR:      addr = {row_r, col_r};
      AD_LEFT:     addr = {row_r, rc_dec(col_r)};
      AD_RIGHT:    addr = {row_r, rc_inc(col_r)};
      AD_DOWN:     addr = {rc_inc(row_r), col_r};
      AD_UP:       addr = {rc_dec(row_r), col_r};
      AD_SCAN:     addr = {scan_i_r, scan_j_r};
      AD_SC_DOWN:  addr = {rc_inc(scan_i_r), scan_j_r};
      AD_SC_RIGHT: addr = {scan_i_r, rc_inc(scan_j_r)};
      default:     addr = {row_r, col_r};
    endcase
  end

  // over-relaxed angle: 2*atan2 - theta, rounded to the stored phase
  assign or_wide = {cz_r[WIDE_W-2:0], 1'b0} - to_wide(th_r)
                   + (WIDE_W'(1) << (UPSHIFT - 1));

  // store write data
  always_comb begin
    unique case (cmd.wr_sel)
      WR_ZERO: wdata = '0;
      WR_ARG:  wdata = arg_r;
      WR_ROT:  wdata = th_r + arg_r;
      WR_OR:   wdata = or_wide[WIDE_W-1:UPSHIFT];
      default: wdata = '0;
    endcase
  end

  // angle store, one access a cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= wdata;
    if (cmd.mem_rd) rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_sel_d_r <= CAP_NONE;
    else        cap_sel_d_r <= cmd.mem_rd ? cmd.cap_sel : CAP_NONE;
    cap_idx_d_r <= cmd.idx;
  end

  // site registers, loaded from the read data in the cycle after the read; a store write loads na_r instead
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      na_r <= wdata;
    end else begin
      unique case (cap_sel_d_r)
        CAP_CTR: begin
          th_r <= rd_q;
          na_r <= rd_q;
        end
        CAP_TH:  th_r <= rd_q;
        CAP_NB:  nb_r[cap_idx_d_r] <= rd_q;
        default: ;
      endcase
    end
  end

  // phase for the sine unit; cos is a quarter turn ahead
  always_comb begin
    unique case (cmd.ph_sel)
      PH_DIFF:   phase = to_wide(th_r) - to_wide(nb_r[cmd.idx]) + QUARTER;
      PH_DIFFD:  phase = to_wide(th_r) - to_wide(nb_r[cmd.idx]) + to_wide(arg_r) + QUARTER;
      PH_NB_COS: phase = to_wide(nb_r[cmd.idx]) + QUARTER;
      PH_NB_SIN: phase = to_wide(nb_r[cmd.idx]);
      PH_TH_COS: phase = to_wide(th_r) + QUARTER;
      PH_TH_SIN: phase = to_wide(th_r);
      default:   phase = to_wide(th_r);
    endcase
  end

  xyl_sin u_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.trig_go),
    .phase  (phase),
    .done   (trig_done),
    .result (sin_res)
  );

  assign sin_ext = ACC_W'(sin_res);
  assign xs = acc_x_r[ACC_W-1] ? -acc_x_r : acc_x_r;
  assign ys = acc_x_r[ACC_W-1] ? -acc_y_r : acc_y_r;

  // accumulators; x/y also feed the CORDIC and the magnitude
  always_ff @(posedge clk) begin
    if (cmd.trig_go) pend_op_r <= cmd.acc_op;
    if (acc_in) begin
      acc_v_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (trig_done) begin
      unique case (pend_op_r)
        ACC_ADD_V: acc_v_r <= acc_v_r + sin_ext;
        ACC_SUB_V: acc_v_r <= acc_v_r - sin_ext;
        ACC_ADD_X: acc_x_r <= acc_x_r + sin_ext;
        ACC_ADD_Y: acc_y_r <= acc_y_r + sin_ext;
        default: ;
      endcase
    end else if (cmd.sq_abs) begin
      acc_x_r <= acc_x_r[ACC_W-1] ? -acc_x_r : acc_x_r;
      acc_y_r <= acc_y_r[ACC_W-1] ? -acc_y_r : acc_y_r;
    end
  end

  // CORDIC vectoring, one micro-rotation a cycle
  assign dx = shr_s(cy_r, cmd.step);
  assign dy = shr_s(cx_r, cmd.step);

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cx_r <= CRD_W'(xs) <<< CRD_PRE;
      cy_r <= CRD_W'(ys) <<< CRD_PRE;
      cz_r <= acc_x_r[ACC_W-1] ? HALF : '0;
    end else if (cmd.cord_step) begin
      if (!cy_r[CRD_W-1] && (cy_r != '0)) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + arc_at(cmd.step);
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - arc_at(cmd.step);
      end
    end
  end

  // magnitude: squares, then bit-pair integer square root
  assign sq_px    = acc_x_r[29:0] * acc_x_r[29:0];
  assign sq_py    = acc_y_r[29:0] * acc_y_r[29:0];
  assign sq_trial = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      sq_v_r   <= SQ_W'(sq_px);
      sq_big_r <= (|acc_x_r[ACC_W-2:LIM_BIT]) || (|acc_y_r[ACC_W-2:LIM_BIT]);
    end else if (cmd.sq_y) begin
      sq_v_r   <= sq_v_r + SQ_W'(sq_py);
      sq_res_r <= '0;
      sq_bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.sq_step) begin
      if (sq_v_r >= sq_trial) begin
        sq_v_r   <= sq_v_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in)             degen_r <= 1'b0;
    else if (cmd.set_degen) degen_r <= 1'b1;
  end

  // result value by kind, saturated
  always_comb begin
    if (acc_v_r > VAL_LIM)       val_sat = VAL_W'(VAL_LIM);
    else if (acc_v_r < -VAL_LIM) val_sat = -VAL_W'(VAL_LIM);
    else                         val_sat = VAL_W'(acc_v_r);
    unique case (kind_r)
      K_DELTA, K_SITE, K_TOTAL: val_res = val_sat;
      K_MAG: val_res = (sq_big_r || (sq_res_r > SQ_LIM)) ? VAL_W'(VAL_LIM)
                                                         : $signed(sq_res_r[VAL_W-1:0]);
      default: val_res = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)            out_v_r <= 1'b0;
    else if (cmd.res_load) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_val_r <= val_res;
      out_na_r  <= na_r;
      out_dg_r  <= degen_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.value      = out_val_r;
  assign out_ch.new_angle  = out_na_r;
  assign out_ch.degenerate = out_dg_r;

  assign sts.in_valid  = in_ch.valid;
  assign sts.kind      = kind_r;
  assign sts.trig_done = trig_done;
  assign sts.scan_last = (scan_i_r == RC_W'(SIDE - 1)) && (scan_j_r == RC_W'(SIDE - 1));
  assign sts.h_zero    = (acc_x_r == '0) && (acc_y_r == '0);
  assign sts.out_free  = !out_v_r || out_ch.ready;

endmodule

`default_nettype wire

FILE: design/xyl_ctrl.sv
// ---------------------------------------------------------------------------
// xyl_ctrl
// Sequencer: store clearing, site fetch, trig terms, CORDIC, square root
// and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xyl_ctrl
  import xyl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire xyl_sts_t sts,
  output xyl_cmd_t      cmd
);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_RD        = 5'd2;
  localparam logic [4:0] S_RDW       = 5'd3;
  localparam logic [4:0] S_DISP      = 5'd4;
  localparam logic [4:0] S_TRIG      = 5'd5;
  localparam logic [4:0] S_TWAIT     = 5'd6;
  localparam logic [4:0] S_CORD_INIT = 5'd7;
  localparam logic [4:0] S_CORD      = 5'd8;
  localparam logic [4:0] S_OR_WR     = 5'd9;
  localparam logic [4:0] S_SC_RD     = 5'd10;
  localparam logic [4:0] S_SC_W      = 5'd11;
  localparam logic [4:0] S_SC_T      = 5'd12;
  localparam logic [4:0] S_SC_TW     = 5'd13;
  localparam logic [4:0] S_SQ_ABS    = 5'd14;
  localparam logic [4:0] S_SQ_X      = 5'd15;
  localparam logic [4:0] S_SQ_Y      = 5'd16;
  localparam logic [4:0] S_SQ_IT     = 5'd17;
  localparam logic [4:0] S_FIN       = 5'd18;

  logic [4:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              term_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign term_last = (sts.kind == K_SITE) ? (step_r == STEP_W'(3)) : (step_r == STEP_W'(7));

  always_comb begin
    cmd       = '0;
    cmd.step  = step_r;
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      // zero every site after reset
      S_CLEAR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AD_SCAN;
        cmd.wr_sel   = WR_ZERO;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_RD;
          step_nxt  = '0;
        end
      end
      // centre, left, right, down, up
      S_RD: begin
        cmd.mem_rd = 1'b1;
        unique case (step_r)
          STEP_W'(0): begin
            cmd.addr_sel = AD_CTR;
            cmd.cap_sel  = CAP_CTR;
          end
          STEP_W'(1): begin
            cmd.addr_sel = AD_LEFT;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd0;
          end
          STEP_W'(2): begin
            cmd.addr_sel = AD_RIGHT;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd1;
          end
          STEP_W'(3): begin
            cmd.addr_sel = AD_DOWN;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd2;
          end
          default: begin
            cmd.addr_sel = AD_UP;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd3;
          end
        endcase
        if (step_r == STEP_W'(4)) state_nxt = S_RDW;
        else                      step_nxt  = step_r + STEP_W'(1);
      end
      S_RDW: begin
        state_nxt = S_DISP;
        step_nxt  = '0;
      end
      S_DISP: begin
        unique case (sts.kind)
          K_SET: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = AD_CTR;
            cmd.wr_sel   = WR_ARG;
            state_nxt    = S_FIN;
          end
          K_ROT: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = AD_CTR;
            cmd.wr_sel   = WR_ROT;
            state_nxt    = S_FIN;
          end
          K_DELTA, K_SITE, K_ORX: state_nxt = S_TRIG;
          K_TOTAL, K_MAG: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SC_RD;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      // one neighbour term per pass through the sine unit
      S_TRIG: begin
        cmd.trig_go = 1'b1;
        unique case (sts.kind)
          K_DELTA: begin
            cmd.idx    = step_r[2:1];
            cmd.ph_sel = step_r[0] ? PH_DIFFD : PH_DIFF;
            cmd.acc_op = step_r[0] ? ACC_SUB_V : ACC_ADD_V;
          end
          K_SITE: begin
            cmd.idx    = step_r[1:0];
            cmd.ph_sel = PH_DIFF;
            cmd.acc_op = ACC_SUB_V;
          end
          default: begin
            cmd.idx    = step_r[2:1];
            cmd.ph_sel = step_r[0] ? PH_NB_SIN : PH_NB_COS;
            cmd.acc_op = step_r[0] ? ACC_ADD_Y : ACC_ADD_X;
          end
        endcase
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (sts.trig_done) begin
          if (term_last) begin
            state_nxt = (sts.kind == K_ORX) ? S_CORD_INIT : S_FIN;
          end else begin
            step_nxt  = step_r + STEP_W'(1);
            state_nxt = S_TRIG;
          end
        end
      end
      S_CORD_INIT: begin
        if (sts.h_zero) begin
          cmd.set_degen = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.cord_init = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = S_OR_WR;
        else                                     step_nxt  = step_r + STEP_W'(1);
      end
      S_OR_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AD_CTR;
        cmd.wr_sel   = WR_OR;
        state_nxt    = S_FIN;
      end
      // whole-lattice walk: site, then down and right for energy
      S_SC_RD: begin
        cmd.mem_rd = 1'b1;
        unique case (step_r)
          STEP_W'(0): begin
            cmd.addr_sel = AD_SCAN;
            cmd.cap_sel  = CAP_TH;
          end
          STEP_W'(1): begin
            cmd.addr_sel = AD_SC_DOWN;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd2;
          end
          default: begin
            cmd.addr_sel = AD_SC_RIGHT;
            cmd.cap_sel  = CAP_NB;
            cmd.idx      = 2'd1;
          end
        endcase
        if ((sts.kind == K_MAG) || (step_r == STEP_W'(2))) state_nxt = S_SC_W;
        else                                              step_nxt  = step_r + STEP_W'(1);
      end
      S_SC_W: begin
        step_nxt  = '0;
        state_nxt = S_SC_T;
      end
      S_SC_T: begin
        cmd.trig_go = 1'b1;
        if (sts.kind == K_MAG) begin
          cmd.ph_sel = step_r[0] ? PH_TH_SIN : PH_TH_COS;
          cmd.acc_op = step_r[0] ? ACC_ADD_Y : ACC_ADD_X;
        end else begin
          cmd.idx    = step_r[0] ? 2'd1 : 2'd2;
          cmd.ph_sel = PH_DIFF;
          cmd.acc_op = ACC_SUB_V;
        end
        state_nxt = S_SC_TW;
      end
      S_SC_TW: begin
        if (sts.trig_done) begin
          if (step_r[0]) begin
            cmd.scan_inc = 1'b1;
            step_nxt     = '0;
            if (sts.scan_last) state_nxt = (sts.kind == K_MAG) ? S_SQ_ABS : S_FIN;
            else               state_nxt = S_SC_RD;
          end else begin
            step_nxt  = STEP_W'(1);
            state_nxt = S_SC_T;
          end
        end
      end
      S_SQ_ABS: begin
        cmd.sq_abs = 1'b1;
        state_nxt  = S_SQ_X;
      end
      S_SQ_X: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.sq_y  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_SQ_IT;
      end
      S_SQ_IT: begin
        cmd.sq_step = 1'b1;
        if (step_r == STEP_W'(SQ_STEPS - 1)) state_nxt = S_FIN;
        else                                 step_nxt  = step_r + STEP_W'(1);
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/xy_lattice_spin_engine.sv
// ---------------------------------------------------------------------------
// XY lattice spin engine
// 64 x 64 periodic lattice of 16-bit spin angles with energy, over-relaxation
// and magnetisation operations.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one operation per transaction (kind, row, col, angle).
//   out_ch : exactly one result transaction per request (value, new_angle,
//            degenerate), in request order.
//   One request is worked on at a time; in_ch.ready is high only while the
//   sequencer is idle. Every request first reads five sites. Set and rotate
//   then finish. Each trig term passes the five-stage sine unit with one
//   term in flight; over-relax adds its 21 CORDIC steps. Total energy and
//   magnetisation walk all 4096 sites, magnetisation followed by a square
//   root. After reset the store is cleared one site a cycle, and no request
//   is taken before the clearing ends.
//   The result sits in an output register; a stalled receiver holds it there
//   and the next request is accepted meanwhile, but its result waits until
//   the register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xy_lattice_spin_engine_defines.svh"

module xy_lattice_spin_engine
  import xyl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  xyl_in_if.sink    in_ch,
  xyl_out_if.source out_ch
);

  xyl_cmd_t cmd;
  xyl_sts_t sts;

  // sequencer
  xyl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // store and arithmetic
  xyl_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // checks
  `XYL_ASSERT_IMP(a_no_rd_wr, cmd.mem_wr, !cmd.mem_rd, "store read and write in one cycle")
  `XYL_ASSERT_IMP(a_load_free, cmd.res_load, sts.out_free, "result loaded over waiting transaction")
  `XYL_ASSERT_NXT(a_busy_after_acc, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken while busy")
  `XYL_ASSERT_IMP(a_trig_single, cmd.trig_go, !sts.trig_done, "sine issue overlaps a pending term")

endmodule

`default_nettype wire
